[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check.
`define LPIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication check.
`define LPIS_ASSERT_IMP(lbl, ante, cons, msg) \
  `LPIS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication check.
`define LPIS_ASSERT_NXT(lbl, ante, cons, msg) \
  `LPIS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[rtl/lpis_pkg.sv]
// ----------------------------------------------------------------------------
// lpis_pkg
// Types and constants of the linear probing intern set.
// ----------------------------------------------------------------------------
`default_nettype none

package lpis_pkg;

  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned HASH_W = 32;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned ENT_W  = 1 + HASH_W + KEY_W;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 10'd1023;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 10'd768;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CMP
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[rtl/lpis_ram.sv]
// ----------------------------------------------------------------------------
// lpis_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lpis_engine.sv]
// ----------------------------------------------------------------------------
// lpis_engine
// Probe sequencer: clears the table after reset, walks slots one read per
// cycle, decides hit / insert / absent / full and writes new entries back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpis_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          func_i,
  input  wire logic [lpis_pkg::HASH_W-1:0]   key_hash_i,
  input  wire logic [lpis_pkg::KEY_W-1:0]    key_i,
  input  wire logic [lpis_pkg::CNT_W-1:0]    limit_i,
  output lpis_pkg::mem_req_t                 mem_req_o,
  input  wire logic [lpis_pkg::ENT_W-1:0]    mem_rdata_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [lpis_pkg::SLOT_W-1:0]        slot_o,
  output logic [lpis_pkg::CNT_W-1:0]         count_o
);

  localparam logic [lpis_pkg::IDX_W-1:0] IDX_LAST = lpis_pkg::IDX_W'(lpis_pkg::SLOTS - 1);

  lpis_pkg::state_e                state_q, state_d;
  logic [lpis_pkg::IDX_W-1:0]      idx_q, step_q;
  logic [lpis_pkg::CNT_W-1:0]      count_q;
  logic                            done_q;
  logic                            func_q;
  logic [lpis_pkg::HASH_W-1:0]     hash_q;
  logic [lpis_pkg::KEY_W-1:0]      key_q;
  lpis_pkg::status_e               status_q, res_status;
  logic [lpis_pkg::IDX_W-1:0]      slot_q, res_slot;

  lpis_pkg::entry_t                ent;
  lpis_pkg::mem_req_t              mem_req;
  logic                            match, empty, last, finish, do_ins;
  logic [lpis_pkg::IDX_W-1:0]      idx_inc, start_idx;

  assign ent       = lpis_pkg::entry_t'(mem_rdata_i);
  assign match     = ent.valid && (ent.hash == hash_q) && (ent.key == key_q);
  assign empty     = !ent.valid;
  assign last      = (step_q == IDX_LAST);
  assign finish    = match || empty || last;
  assign idx_inc   = (idx_q == IDX_LAST) ? '0 : idx_q + lpis_pkg::IDX_W'(1);
  assign start_idx = lpis_pkg::IDX_W'(key_hash_i & lpis_pkg::HASH_W'(lpis_pkg::SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpis_pkg::S_CLEAR: begin
        if (idx_q == IDX_LAST) state_d = lpis_pkg::S_IDLE;
      end
      lpis_pkg::S_IDLE: begin
        if (start_i) state_d = lpis_pkg::S_CMP;
      end
      lpis_pkg::S_CMP: begin
        if (finish) state_d = lpis_pkg::S_IDLE;
      end
      default: state_d = lpis_pkg::S_IDLE;
    endcase
  end

  // memory requests and decision
  always_comb begin
    mem_req    = '0;
    res_status = lpis_pkg::ST_ABSENT;
    res_slot   = '0;
    do_ins     = 1'b0;
    unique case (state_q)
      lpis_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q;
      end
      lpis_pkg::S_IDLE: begin
        mem_req.re    = start_i;
        mem_req.raddr = start_idx;
      end
      lpis_pkg::S_CMP: begin
        mem_req.re    = !finish;
        mem_req.raddr = idx_inc;
        priority if (match) begin
          res_status = lpis_pkg::ST_HIT;
          res_slot   = idx_q;
        end else if (!func_q) begin
          res_status = lpis_pkg::ST_ABSENT;
        end else if (!empty || (count_q > limit_i) || (count_q == lpis_pkg::COUNT_MAX)) begin
          res_status = lpis_pkg::ST_FULL;
        end else begin
          res_status          = lpis_pkg::ST_INSERTED;
          res_slot            = idx_q;
          do_ins              = 1'b1;
          mem_req.we          = 1'b1;
          mem_req.waddr       = idx_q;
          mem_req.wdata.valid = 1'b1;
          mem_req.wdata.hash  = hash_q;
          mem_req.wdata.key   = key_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpis_pkg::S_CLEAR;
      idx_q   <= '0;
      step_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lpis_pkg::S_CMP) && finish;
      unique case (state_q)
        lpis_pkg::S_CLEAR: begin
          idx_q <= idx_inc;
        end
        lpis_pkg::S_IDLE: begin
          if (start_i) begin
            idx_q  <= start_idx;
            step_q <= '0;
          end
        end
        lpis_pkg::S_CMP: begin
          if (!finish) begin
            idx_q  <= idx_inc;
            step_q <= step_q + lpis_pkg::IDX_W'(1);
          end
          if (do_ins) count_q <= count_q + lpis_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpis_pkg::S_IDLE && start_i) begin
      func_q <= func_i;
      hash_q <= key_hash_i;
      key_q  <= key_i;
    end
    if (state_q == lpis_pkg::S_CMP && finish) begin
      status_q <= res_status;
      slot_q   <= res_slot;
    end
  end

  assign busy_o    = (state_q != lpis_pkg::S_IDLE);
  assign mem_req_o = mem_req;
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign slot_o    = lpis_pkg::SLOT_W'(slot_q);
  assign count_o   = count_q;

  `LPIS_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
  `LPIS_ASSERT_IMP(a_count_on_insert, count_q != $past(count_q), done_q && status_q == lpis_pkg::ST_INSERTED, "entry count moved without an insert")
  `LPIS_ASSERT_IMP(a_write_state, mem_req.we, state_q == lpis_pkg::S_CLEAR || state_q == lpis_pkg::S_CMP, "table write outside clear or compare")
  `LPIS_ASSERT_IMP(a_no_rw_clash, mem_req.we && mem_req.re, 1'b0, "read and write in the same cycle")

endmodule

`default_nettype wire

[rtl/linear_probe_intern_set.sv]
// ----------------------------------------------------------------------------
// linear_probe_intern_set
// Open-addressed hash set with linear probing, fixed capacity, load limit.
// ----------------------------------------------------------------------------
// Each request probes P slots (P >= 1), one table read per probe cycle; a new
// request is taken only after the previous one has finished (busy is low).
// Reset: a clearing pass writes all 1024 slots, one per cycle, with busy
// high throughout the pass. load_limit resets to 768, count to 0.
// Results cannot be stalled: done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_intern_set (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        func_i,
  input  wire logic [lpis_pkg::HASH_W-1:0] key_hash_i,
  input  wire logic [lpis_pkg::KEY_W-1:0]  key_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [lpis_pkg::SLOT_W-1:0]      slot_o,
  output logic [lpis_pkg::CNT_W-1:0]       entry_count_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lpis_pkg::CNT_W-1:0]  cfg_load_limit_i
);

  logic [lpis_pkg::CNT_W-1:0] limit_q;
  lpis_pkg::mem_req_t         mem_req;
  logic [lpis_pkg::ENT_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lpis_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_load_limit_i;
    end
  end

  lpis_ram #(
    .WIDTH (lpis_pkg::ENT_W),
    .DEPTH (lpis_pkg::SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  lpis_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .func_i      (func_i),
    .key_hash_i  (key_hash_i),
    .key_i       (key_i),
    .limit_i     (limit_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .count_o     (entry_count_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_intern_set. Requests are driven
// through the start/busy handshake with random gaps. Each accepted request is
// run through a local copy of the hash table to predict status, slot and
// count, and the single result per request is checked on its done strobe. The
// table is never cleared after reset, so the run moves from an empty table
// through moderate load to the count ceiling.
// ----------------------------------------------------------------------------

module tb;

  localparam logic        FN_LOOKUP  = 1'b0;
  localparam logic        FN_INTERN  = 1'b1;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned TAIL_WAIT  = 1100;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    lpis_pkg::status_e               status;
    logic [lpis_pkg::SLOT_W-1:0]     slot;
    logic [lpis_pkg::CNT_W-1:0]      count;
  } result_t;

  logic                            clk_i            = 1'b0;
  logic                            rst_ni           = 1'b0;
  logic                            start            = 1'b0;
  logic                            busy;
  logic                            func_i           = 1'b0;
  logic [lpis_pkg::HASH_W-1:0]     key_hash_i       = '0;
  logic [lpis_pkg::KEY_W-1:0]      key_i            = '0;
  logic                            done_o;
  logic [1:0]                      status_o;
  logic [lpis_pkg::SLOT_W-1:0]     slot_o;
  logic [lpis_pkg::CNT_W-1:0]      entry_count_o;
  logic                            cfg_valid_i      = 1'b0;
  logic                            cfg_ready_o;
  logic [lpis_pkg::CNT_W-1:0]      cfg_load_limit_i = '0;

  // local copy of the table
  bit                                          tab_valid [lpis_pkg::SLOTS];
  logic [lpis_pkg::HASH_W-1:0]                 tab_hash  [lpis_pkg::SLOTS];
  logic [lpis_pkg::KEY_W-1:0]                  tab_key   [lpis_pkg::SLOTS];
  logic [lpis_pkg::CNT_W-1:0]                  n_stored;
  logic [lpis_pkg::CNT_W-1:0]                  load_limit;
  logic [lpis_pkg::HASH_W+lpis_pkg::KEY_W-1:0] known_q [$];
  result_t                                     expected_q [$];

  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  bit          burst_mode   = 1'b0;

  linear_probe_intern_set i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .key_hash_i       (key_hash_i),
    .key_i            (key_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .entry_count_o    (entry_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_load_limit_i (cfg_load_limit_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic result_t intern_predict(input logic fn,
                                             input logic [lpis_pkg::HASH_W-1:0] h,
                                             input logic [lpis_pkg::KEY_W-1:0] k);
    result_t                      r;
    logic [lpis_pkg::IDX_W-1:0]   idx;
    logic [lpis_pkg::IDX_W-1:0]   free_idx;
    bit                           hit;
    bit                           free_seen;
    idx       = h[lpis_pkg::IDX_W-1:0];
    free_idx  = '0;
    hit       = 1'b0;
    free_seen = 1'b0;
    for (int n = 0; n < lpis_pkg::SLOTS; n++) begin
      if (!tab_valid[idx]) begin
        free_seen = 1'b1;
        free_idx  = idx;
        break;
      end
      if (tab_hash[idx] == h && tab_key[idx] == k) begin
        hit = 1'b1;
        break;
      end
      idx = idx + lpis_pkg::IDX_W'(1);
    end
    r.slot = '0;
    if (hit) begin
      r.status = lpis_pkg::ST_HIT;
      r.slot   = idx;
    end else if (fn == FN_LOOKUP) begin
      r.status = lpis_pkg::ST_ABSENT;
    end else if (!free_seen || n_stored > load_limit || n_stored >= lpis_pkg::COUNT_MAX) begin
      r.status = lpis_pkg::ST_FULL;
    end else begin
      tab_valid[free_idx] = 1'b1;
      tab_hash[free_idx]  = h;
      tab_key[free_idx]   = k;
      n_stored            = n_stored + lpis_pkg::CNT_W'(1);
      known_q.push_back({h, k});
      r.status = lpis_pkg::ST_INSERTED;
      r.slot   = free_idx;
    end
    r.count = n_stored;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // start stays high when the next request follows without a gap
  task automatic send_req(input logic fn, input logic [lpis_pkg::HASH_W-1:0] h,
                          input logic [lpis_pkg::KEY_W-1:0] k);
    start      <= 1'b1;
    func_i     <= fn;
    key_hash_i <= h;
    key_i      <= k;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    expected_q.push_back(intern_predict(fn, h, k));
    idle_for(pick_gap());
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_load_limit(input logic [lpis_pkg::CNT_W-1:0] v);
    drain();
    cfg_valid_i      <= 1'b1;
    cfg_load_limit_i <= v;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    load_limit = v;
  endtask

  task automatic test_empty_after_reset();
    send_req(FN_LOOKUP, '0, '0);
    send_req(FN_LOOKUP, '1, '1);
    send_req(FN_LOOKUP, 32'h8000_0200, 64'h0000_0001_8000_0000);
  endtask

  task automatic test_load_refusal();
    set_load_limit(10'd1);
    send_req(FN_INTERN, 32'h0000_0000, 64'h0);
    send_req(FN_INTERN, 32'h0000_0400, 64'h0);           // same start slot
    send_req(FN_INTERN, 32'hFFFF_FFFF, '1);              // count above limit
    send_req(FN_INTERN, 32'h0000_0000, 64'h0);           // hit despite limit
    send_req(FN_LOOKUP, 32'h0000_0400, 64'h0);
    send_req(FN_LOOKUP, 32'h0000_0000, 64'h1);           // key differs only
    send_req(FN_LOOKUP, 32'hFFFF_FFFF, '1);
  endtask

  task automatic test_probe_wrap();
    set_load_limit(10'd1022);
    send_req(FN_INTERN, 32'hFFFF_FFFF, '1);
    send_req(FN_INTERN, 32'h8000_03FF, '1);              // wraps past slot 0
    send_req(FN_LOOKUP, 32'h8000_03FF, '1);
    send_req(FN_INTERN, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
    send_req(FN_LOOKUP, 32'h0000_0003, 64'h8000_0000_0000_0000);
    send_req(FN_INTERN, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(FN_INTERN, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
    send_req(FN_LOOKUP, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(FN_INTERN, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
  endtask

  task automatic test_random_traffic(input int unsigned n_items,
                                     input logic [lpis_pkg::CNT_W-1:0] limit);
    logic [lpis_pkg::HASH_W-1:0] h;
    logic [lpis_pkg::KEY_W-1:0]  k;
    logic                        fn;
    int unsigned                 pick;
    set_load_limit(limit);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      fn   = $urandom_range(0, 1) ? FN_INTERN : FN_LOOKUP;
      h    = $urandom;
      k    = {$urandom, $urandom};
      if (pick < 45 && known_q.size() != 0) begin
        {h, k} = known_q[$urandom_range(0, known_q.size() - 1)];
        if (pick >= 35) k = k ^ (64'd1 << $urandom_range(0, lpis_pkg::KEY_W - 1));
        else if (pick >= 30)
          h = h ^ (32'd1 << $urandom_range(lpis_pkg::IDX_W, lpis_pkg::HASH_W - 1));
      end else begin
        fn = ($urandom_range(0, 9) < 6) ? FN_INTERN : FN_LOOKUP;
        if (pick >= 90) k = $urandom_range(0, 1) ? '1 : '0;
        else if (pick >= 80)
          h[lpis_pkg::IDX_W-1:0] = 10'd1019 + 10'($urandom_range(0, 8));
        else if (pick >= 72)
          h[lpis_pkg::IDX_W-1:0] = 10'd300 + 10'($urandom_range(0, 15));
      end
      send_req(fn, h, k);
      if ($urandom_range(0, 199) == 0) drain();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_fill_to_ceiling();
    logic [lpis_pkg::IDX_W-1:0]  s;
    logic [lpis_pkg::HASH_W-1:0] h;
    logic [lpis_pkg::KEY_W-1:0]  k;
    set_load_limit(10'd1022);
    while (n_stored < lpis_pkg::COUNT_MAX) begin
      if ($urandom_range(0, 15) == 0) begin
        {h, k} = known_q[$urandom_range(0, known_q.size() - 1)];
      end else begin
        s = lpis_pkg::IDX_W'($urandom);
        while (tab_valid[s]) s = s + lpis_pkg::IDX_W'(1);
        h = $urandom;
        h[lpis_pkg::IDX_W-1:0] = s;
        k = {$urandom, $urandom};
      end
      send_req(FN_INTERN, h, k);
    end
    // one slot left free, count at its ceiling
    for (int i = 0; i < 24; i++) begin
      h = $urandom;
      k = {$urandom, $urandom};
      if (i % 3 == 0) {h, k} = known_q[$urandom_range(0, known_q.size() - 1)];
      send_req((i % 2 != 0) ? FN_INTERN : FN_LOOKUP, h, k);
    end
  endtask

  task automatic test_refusal_above_limit();
    logic [lpis_pkg::HASH_W-1:0] h;
    logic [lpis_pkg::KEY_W-1:0]  k;
    set_load_limit(10'($urandom_range(1, 1021)));
    for (int i = 0; i < 8; i++) begin
      h = $urandom;
      k = {$urandom, $urandom};
      if (i % 2 == 0) {h, k} = known_q[$urandom_range(0, known_q.size() - 1)];
      send_req(FN_INTERN, h, k);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d slot %0d count %0d",
                                  status_o, slot_o, entry_count_o));
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, exp_r.status));
        if (slot_o !== exp_r.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot_o, exp_r.slot));
        if (entry_count_o !== exp_r.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count_o,
                                    exp_r.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < lpis_pkg::SLOTS; i++) begin
      tab_valid[i] = 1'b0;
      tab_hash[i]  = '0;
      tab_key[i]   = '0;
    end
    n_stored   = '0;
    load_limit = lpis_pkg::LIMIT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_after_reset();
    test_load_refusal();
    test_probe_wrap();
    test_random_traffic(250, 10'd60);
    test_random_traffic(250, 10'($urandom_range(300, 500)));
    test_random_traffic(200, lpis_pkg::LIMIT_RESET);
    test_fill_to_ceiling();
    test_refusal_above_limit();

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
